// ===== rtl/core/bosa_pkg.sv =====
// Shared types and constants of the bounded edit-distance block.
// No dependencies; every other file imports this package.

package bosa_pkg;

	localparam int LEN_W  = 6;
	localparam int CHAR_W = 8;
	localparam int CUT_W  = 6;
	localparam int DIST_W = 7;

	typedef enum logic [1:0] {
		KIND_CLEAR_SRC  = 2'd0,
		KIND_APPEND_SRC = 2'd1,
		KIND_APPEND_TGT = 2'd2,
		KIND_COMPUTE    = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [CHAR_W-1:0]  char_code;
		logic [CUT_W-1:0]   cutoff;
	} in_item_t;

	typedef struct packed {
		logic [DIST_W-1:0]  distance;
		logic               over_bound;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_ROW_LOAD,
		ST_CELLS,
		ST_DRAIN,
		ST_ROW_END,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		RES_SENTINEL,
		RES_SUM,
		RES_LAST
	} res_sel_t;

	typedef struct packed {
		logic              take;
		logic              row_load;
		logic              cell_rd;
		logic              res_load;
		res_sel_t          res_sel;
		logic              out_load;
		logic [LEN_W-1:0]  row_i;
		logic [LEN_W-1:0]  col_j;
	} cmd_t;

	typedef struct packed {
		logic [LEN_W-1:0]  src_len;
		logic [LEN_W-1:0]  tgt_len;
		logic              reject;
		logic              trivial;
		logic              row_over;
		logic              out_busy;
	} sts_t;

endpackage

// ===== rtl/core/bosa_in_if.sv =====
// Input channel of the bounded edit-distance block: valid, ready and one item.
// Depends on bosa_pkg for the item type.

interface bosa_in_if import bosa_pkg::*; ();
	logic      valid;
	logic      ready;
	in_item_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/bosa_out_if.sv =====
// Result channel of the bounded edit-distance block: valid, ready and one item.
// Depends on bosa_pkg for the item type.

interface bosa_out_if import bosa_pkg::*; ();
	logic       valid;
	logic       ready;
	out_item_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/bosa_ctrl.sv =====
// Sequencer of the bounded edit-distance block: walks rows and columns of the
// dynamic programme and issues commands to the datapath. Depends on bosa_pkg.

module bosa_ctrl import bosa_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  kind_t  in_kind,
	output logic   in_ready,
	input  sts_t   sts,
	output cmd_t   cmd
);

	state_t            state_q, state_d;
	logic [LEN_W-1:0]  i_q, i_d;
	logic [LEN_W-1:0]  j_q, j_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		i_d         = i_q;
		j_d         = j_q;
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.res_sel = RES_SENTINEL;
		cmd.row_i   = i_q;
		cmd.col_j   = j_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					if (in_kind == KIND_COMPUTE) begin
						state_d = ST_START;
					end
				end
			end
			ST_START: begin
				if (sts.reject) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_SENTINEL;
					state_d      = ST_DONE;
				end else if (sts.trivial) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_SUM;
					state_d      = ST_DONE;
				end else begin
					i_d     = LEN_W'(1);
					state_d = ST_ROW_LOAD;
				end
			end
			ST_ROW_LOAD: begin
				cmd.row_load = 1'b1;
				j_d          = LEN_W'(1);
				state_d      = ST_CELLS;
			end
			ST_CELLS: begin
				cmd.cell_rd = 1'b1;
				if (j_q == sts.tgt_len) begin
					state_d = ST_DRAIN;
				end else begin
					j_d = j_q + LEN_W'(1);
				end
			end
			ST_DRAIN: begin
				state_d = ST_ROW_END;
			end
			ST_ROW_END: begin
				if (sts.row_over) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_SENTINEL;
					state_d      = ST_DONE;
				end else if (i_q == sts.src_len) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_LAST;
					state_d      = ST_DONE;
				end else begin
					i_d     = i_q + LEN_W'(1);
					state_d = ST_ROW_LOAD;
				end
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/bosa_dp.sv =====
// Datapath of the bounded edit-distance block: string stores, row store,
// one-cell update unit and the result register. Depends on bosa_pkg.

module bosa_dp import bosa_pkg::*; #(
	parameter int MAX_LEN = 40
) (
	input  logic       clk,
	input  logic       arst_n,
	input  in_item_t   in_item,
	input  cmd_t       cmd,
	output sts_t       sts,
	input  logic       out_ready,
	output logic       out_valid,
	output out_item_t  out_item
);

	localparam int RA_W = $clog2(MAX_LEN + 1);
	localparam int CA_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEN);

	// One column of the row store: the value two rows back and one row back.
	typedef struct packed {
		logic [LEN_W-1:0] tb;
		logic [LEN_W-1:0] ob;
	} row_ent_t;

	logic [CHAR_W-1:0] src_mem [MAX_LEN];
	logic [CHAR_W-1:0] tgt_mem [MAX_LEN];
	row_ent_t          row_mem [MAX_LEN+1];

	logic [LEN_W-1:0]  src_len_q, tgt_len_q;
	logic              src_ovf_q, tgt_ovf_q;
	logic [CUT_W-1:0]  cutoff_q;

	logic [CHAR_W-1:0] src_rd_q, prev_sc_q, tgt_rd_q, tgt_prev_q;
	row_ent_t          row_rd_q;
	logic [LEN_W-1:0]  j_s1;
	logic              first_s1, valid_s1;

	logic [LEN_W-1:0]  i_q, ob_prev_q, now_q, tb1_q, tb2_q, row_min_q;
	logic [DIST_W-1:0] res_q;
	logic              out_valid_q;
	out_item_t         out_item_q;

	logic              app_src, app_tgt;
	logic [LEN_W-1:0]  diff, src_addr_w, tgt_addr_w;
	logic [LEN_W-1:0]  ob_j, v;
	logic              sub, trans;
	logic [DIST_W-1:0] cand_a, cand_b, cand_c, cand_d, m_ab, m_abc, v_full;
	logic [DIST_W-1:0] sentinel, sum, res_next;
	logic              res_over;

	assign app_src = cmd.take && (in_item.kind == KIND_APPEND_SRC);
	assign app_tgt = cmd.take && (in_item.kind == KIND_APPEND_TGT);

	assign diff = (src_len_q >= tgt_len_q) ? (src_len_q - tgt_len_q)
	                                       : (tgt_len_q - src_len_q);

	assign sts.src_len  = src_len_q;
	assign sts.tgt_len  = tgt_len_q;
	assign sts.reject   = src_ovf_q || tgt_ovf_q || (diff > cutoff_q);
	assign sts.trivial  = (src_len_q == '0) || (tgt_len_q == '0);
	assign sts.row_over = row_min_q > cutoff_q;
	assign sts.out_busy = out_valid_q && !out_ready;

	assign src_addr_w = cmd.row_i - LEN_W'(1);
	assign tgt_addr_w = cmd.col_j - LEN_W'(1);

	// String stores.
	always_ff @(posedge clk) begin
		if (app_src && (src_len_q < LEN_MAX)) begin
			src_mem[src_len_q[CA_W-1:0]] <= in_item.char_code;
		end
		if (cmd.row_load) begin
			src_rd_q  <= src_mem[src_addr_w[CA_W-1:0]];
			prev_sc_q <= src_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (app_tgt && (tgt_len_q < LEN_MAX)) begin
			tgt_mem[tgt_len_q[CA_W-1:0]] <= in_item.char_code;
		end
		if (cmd.cell_rd) begin
			tgt_rd_q <= tgt_mem[tgt_addr_w[CA_W-1:0]];
		end
	end

	// Row store: column j is read in the cycle before its update and rewritten
	// with the row that was just finished shifted in.
	always_ff @(posedge clk) begin
		if (cmd.cell_rd) begin
			row_rd_q <= row_mem[cmd.col_j[RA_W-1:0]];
			j_s1     <= cmd.col_j;
			first_s1 <= (cmd.col_j == LEN_W'(1));
		end
		if (valid_s1) begin
			row_mem[j_s1[RA_W-1:0]] <= '{tb: ob_j, ob: v};
		end
	end

	// Cell update. The first row has no stored predecessor, so the values it
	// takes from the row above are the column numbers themselves.
	always_comb begin
		ob_j   = (i_q == LEN_W'(1)) ? j_s1 : row_rd_q.ob;
		sub    = (src_rd_q != tgt_rd_q);
		trans  = (i_q != LEN_W'(1)) && !first_s1 && (src_rd_q == tgt_prev_q) &&
		         (prev_sc_q == tgt_rd_q);
		cand_a = DIST_W'(ob_j) + DIST_W'(1);
		cand_b = DIST_W'(now_q) + DIST_W'(1);
		cand_c = DIST_W'(ob_prev_q) + DIST_W'(sub);
		cand_d = DIST_W'(tb2_q) + DIST_W'(1);
		m_ab   = (cand_a < cand_b) ? cand_a : cand_b;
		m_abc  = (m_ab < cand_c) ? m_ab : cand_c;
		v_full = (trans && (cand_d < m_abc)) ? cand_d : m_abc;
		v      = v_full[LEN_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.row_load) begin
			i_q       <= cmd.row_i;
			ob_prev_q <= cmd.row_i - LEN_W'(1);
			now_q     <= cmd.row_i;
			tb1_q     <= cmd.row_i - LEN_W'(2);
			row_min_q <= cmd.row_i;
		end else if (valid_s1) begin
			now_q      <= v;
			ob_prev_q  <= ob_j;
			tb2_q      <= tb1_q;
			tb1_q      <= row_rd_q.tb;
			tgt_prev_q <= tgt_rd_q;
			row_min_q  <= (v < row_min_q) ? v : row_min_q;
		end
	end

	// Result selection and saturation against the cutoff.
	assign sentinel = DIST_W'(cutoff_q) + DIST_W'(1);
	assign sum      = DIST_W'(src_len_q) + DIST_W'(tgt_len_q);
	assign res_over = res_q > DIST_W'(cutoff_q);

	always_comb begin
		case (cmd.res_sel)
			RES_SENTINEL: res_next = sentinel;
			RES_SUM:      res_next = sum;
			RES_LAST:     res_next = DIST_W'(now_q);
			default:      res_next = sentinel;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.take && (in_item.kind == KIND_COMPUTE)) begin
			cutoff_q <= in_item.cutoff;
		end
		if (cmd.res_load) begin
			res_q <= res_next;
		end
		if (cmd.out_load) begin
			out_item_q.distance   <= res_over ? sentinel : res_q;
			out_item_q.over_bound <= res_over;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_len_q   <= '0;
			tgt_len_q   <= '0;
			src_ovf_q   <= 1'b0;
			tgt_ovf_q   <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= cmd.cell_rd;
			if (cmd.take && (in_item.kind == KIND_CLEAR_SRC)) begin
				src_len_q <= '0;
				src_ovf_q <= 1'b0;
			end else if (app_src) begin
				if (src_len_q < LEN_MAX) begin
					src_len_q <= src_len_q + LEN_W'(1);
				end else begin
					src_ovf_q <= 1'b1;
				end
			end
			if (cmd.out_load) begin
				tgt_len_q <= '0;
				tgt_ovf_q <= 1'b0;
			end else if (app_tgt) begin
				if (tgt_len_q < LEN_MAX) begin
					tgt_len_q <= tgt_len_q + LEN_W'(1);
				end else begin
					tgt_ovf_q <= 1'b1;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

// ===== rtl/core/bounded_osa_edit_distance.sv =====
// Bounded optimal-string-alignment distance, one dynamic-programme cell a cycle.
// Clear and append items are taken back to back while the sequencer is idle.
// A compute item walks its n source rows over its m target columns; a rejected
// or empty case goes straight to its result.
// An early stop ends the compute after the first row whose minimum exceeds the cutoff.
// Reset clears lengths, overflow flags and the sequencer; string stores stay undefined.

module bounded_osa_edit_distance import bosa_pkg::*; #(
	parameter int MAX_LEN = 40
) (
	input  logic           clk,
	input  logic           arst_n,
	bosa_in_if.sink        in_ch,
	bosa_out_if.source     out_ch
);

	// The controller owns the row and column counters and the handshake on
	// the input side. It steps through the states start, row load, cells, drain and
	// row end, or from start straight to done, then hands the result to the output register.
	cmd_t       cmd;
	sts_t       sts;
	in_item_t   in_item;
	out_item_t  out_item;
	logic       out_valid;
	logic       in_ready;

	assign in_item = in_ch.payload;

	bosa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_kind  (in_ch.payload.kind),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds both strings, the row store that keeps two previous
	// rows per column, the single cell update unit and the result register.
	// The result register parts the two sides, so clear and append items are
	// taken while a finished result still waits for the consumer.
	bosa_dp #(
		.MAX_LEN (MAX_LEN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (out_ch.ready),
		.out_valid (out_valid),
		.out_item  (out_item)
	);

	assign in_ch.ready    = in_ready;
	assign out_ch.valid   = out_valid;
	assign out_ch.payload = out_item;

endmodule

// ===== tb/bounded_osa_edit_distance_tb.sv =====
// Self-checking testbench for the bounded edit-distance block: directed table, then random items.
// Depends on bosa_pkg and the bosa_in_if / bosa_out_if channel interfaces of the RTL.
`timescale 1ns / 1ps

module bounded_osa_edit_distance_tb;
	import bosa_pkg::*;

	localparam int STR_MAX      = 40;
	localparam int RANDOM_ITEMS = 1450;
	localparam int IDLE_PCT     = 18;
	// The receiver holds off once for this long while the sender keeps offering items.
	localparam int HOLD_CYCLES  = 3000;
	// Extra wait after the last expected result before the verdict is printed.
	localparam int DRAIN_CYCLES = 2000;
	// Cycle budget for the whole run; reaching it ends the run as a mismatch.
	localparam int CYCLE_LIMIT  = 3000000;

	// One row of the directed table. Where typed is set, exp_dist and over are the expected
	// result of a compute row; every other compute row is checked against the predictor.
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  ch;
		logic [5:0]  cut;
		logic        typed;
		logic [6:0]  exp_dist;
		logic        over;
	} dir_row_t;

	localparam int DIR_ROWS = 24;
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		// Empty source against empty target right after reset; the byte field is ignored.
		'{KIND_COMPUTE,    8'hA5, 6'd0,  1'b1, 7'd0, 1'b0},
		// One target byte against an empty source with cutoff 0: the length gap exceeds it.
		'{KIND_APPEND_TGT, 8'hFF, 6'd63, 1'b0, 7'd0, 1'b0},
		'{KIND_COMPUTE,    8'h00, 6'd0,  1'b1, 7'd1, 1'b1},
		// Extreme bytes swapped between source and target: one adjacent transposition.
		'{KIND_APPEND_SRC, 8'h00, 6'd63, 1'b0, 7'd0, 1'b0},
		'{KIND_APPEND_SRC, 8'hFF, 6'd0,  1'b0, 7'd0, 1'b0},
		'{KIND_APPEND_TGT, 8'hFF, 6'd0,  1'b0, 7'd0, 1'b0},
		'{KIND_APPEND_TGT, 8'h00, 6'd63, 1'b0, 7'd0, 1'b0},
		'{KIND_COMPUTE,    8'hFF, 6'd63, 1'b1, 7'd1, 1'b0},
		// The compute cleared the target, so the same source now meets an equal target.
		'{KIND_APPEND_TGT, 8'h00, 6'd0,  1'b0, 7'd0, 1'b0},
		'{KIND_APPEND_TGT, 8'hFF, 6'd0,  1'b0, 7'd0, 1'b0},
		'{KIND_COMPUTE,    8'h5A, 6'd63, 1'b1, 7'd0, 1'b0},
		// Fresh source "ab" against "cd" with cutoff 1: the second row stops the programme.
		'{KIND_CLEAR_SRC,  8'hFF, 6'd63, 1'b0, 7'd0, 1'b0},
		'{KIND_APPEND_SRC, 8'h61, 6'd0,  1'b0, 7'd0, 1'b0},
		'{KIND_APPEND_SRC, 8'h62, 6'd0,  1'b0, 7'd0, 1'b0},
		'{KIND_APPEND_TGT, 8'h63, 6'd0,  1'b0, 7'd0, 1'b0},
		'{KIND_APPEND_TGT, 8'h64, 6'd0,  1'b0, 7'd0, 1'b0},
		'{KIND_COMPUTE,    8'h00, 6'd1,  1'b1, 7'd2, 1'b1},
		// "ab" against "bc" with cutoff 1: every row stays in bound, the final cell does not.
		'{KIND_APPEND_TGT, 8'h62, 6'd0,  1'b0, 7'd0, 1'b0},
		'{KIND_APPEND_TGT, 8'h63, 6'd0,  1'b0, 7'd0, 1'b0},
		'{KIND_COMPUTE,    8'h00, 6'd1,  1'b1, 7'd2, 1'b1},
		// A single insertion, left to the predictor.
		'{KIND_APPEND_TGT, 8'h61, 6'd0,  1'b0, 7'd0, 1'b0},
		'{KIND_APPEND_TGT, 8'h78, 6'd0,  1'b0, 7'd0, 1'b0},
		'{KIND_APPEND_TGT, 8'h62, 6'd0,  1'b0, 7'd0, 1'b0},
		'{KIND_COMPUTE,    8'h00, 6'd63, 1'b0, 7'd0, 1'b0}
	};

	logic clk;
	logic arst_n;

	bosa_in_if  in_ch ();
	bosa_out_if out_ch ();

	bounded_osa_edit_distance #(
		.MAX_LEN(STR_MAX)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: both strings, their lengths and overflow flags.
	logic [7:0] src_bytes [STR_MAX];
	logic [7:0] tgt_bytes [STR_MAX];
	int         src_len = 0;
	int         tgt_len = 0;
	bit         src_ovf = 1'b0;
	bit         tgt_ovf = 1'b0;

	// Results still owed by the block, oldest first.
	out_item_t  expected_distances [$];
	int         errors = 0;

	// Shared pacing controls: quiet turns idling off on both sides, hold_request asks the
	// receiver for its one long hold-off.
	bit         quiet = 1'b0;
	bit         hold_request = 1'b0;
	bit         hold_taken = 1'b0;
	int         hold_left = 0;
	int         cycle_count = 0;
	out_item_t  oldest;

	// Restricted Damerau-Levenshtein distance of the current strings, three rows at a time,
	// giving cutoff+1 as soon as the bound is known to be exceeded.
	function automatic int osa_bounded_distance(input int cutoff);
		int two_back [STR_MAX+1];
		int one_back [STR_MAX+1];
		int cur [STR_MAX+1];
		int spread;
		int row_min;
		int cell_val;
		int cost;
		spread = (src_len > tgt_len) ? src_len - tgt_len : tgt_len - src_len;
		if (src_ovf || tgt_ovf || spread > cutoff)
			return cutoff + 1;
		for (int j = 0; j <= STR_MAX; j++) begin
			two_back[j] = 0;
			one_back[j] = j;
			cur[j]      = 0;
		end
		for (int i = 1; i <= src_len; i++) begin
			cur[0]  = i;
			row_min = i;
			for (int j = 1; j <= tgt_len; j++) begin
				cost = (src_bytes[i-1] == tgt_bytes[j-1]) ? 0 : 1;
				cell_val = (one_back[j] < cur[j-1]) ? one_back[j] + 1 : cur[j-1] + 1;
				if (one_back[j-1] + cost < cell_val)
					cell_val = one_back[j-1] + cost;
				// Adjacent transposition: the last two bytes appear swapped.
				if (i > 1 && j > 1 && src_bytes[i-1] == tgt_bytes[j-2] &&
						src_bytes[i-2] == tgt_bytes[j-1] && two_back[j-2] + 1 < cell_val)
					cell_val = two_back[j-2] + 1;
				cur[j] = cell_val;
				if (cell_val < row_min)
					row_min = cell_val;
			end
			if (row_min > cutoff)
				return cutoff + 1;
			two_back = one_back;
			one_back = cur;
		end
		if (one_back[tgt_len] > cutoff)
			return cutoff + 1;
		return one_back[tgt_len];
	endfunction

	// Applies one accepted item to the predictor state. Returns 1 with the expected result
	// in res for a compute item, 0 for the others.
	function automatic bit apply_item(input in_item_t it, output out_item_t res);
		int d;
		bit gives = 1'b0;
		res = '0;
		case (it.kind)
			KIND_CLEAR_SRC: begin
				src_len = 0;
				src_ovf = 1'b0;
			end
			KIND_APPEND_SRC: begin
				if (src_len < STR_MAX) begin
					src_bytes[src_len] = it.char_code;
					src_len++;
				end else begin
					src_ovf = 1'b1;
				end
			end
			KIND_APPEND_TGT: begin
				if (tgt_len < STR_MAX) begin
					tgt_bytes[tgt_len] = it.char_code;
					tgt_len++;
				end else begin
					tgt_ovf = 1'b1;
				end
			end
			default: begin
				d = osa_bounded_distance(int'(it.cutoff));
				res.distance   = d[6:0];
				res.over_bound = (d > int'(it.cutoff));
				tgt_len = 0;
				tgt_ovf = 1'b0;
				gives   = 1'b1;
			end
		endcase
		return gives;
	endfunction

	// Bytes come either from a four-letter alphabet, so that matches and transpositions
	// are common, or from the full byte range.
	function automatic logic [7:0] pick_char(input int mode, input logic [7:0] base);
		return (mode < 2) ? base + 8'($urandom_range(3)) : 8'($urandom_range(255));
	endfunction

	// Offers one item, idling first at random, and waits for the handshake. On acceptance
	// the predictor is advanced and any result it owes is queued; a typed result from the
	// directed table takes the place of the predicted one.
	task automatic push_item(input in_item_t it, input bit typed, input out_item_t typed_res);
		out_item_t res;
		while ($urandom_range(99) < (quiet ? 0 : IDLE_PCT)) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.payload <= it;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		if (apply_item(it, res))
			expected_distances = {expected_distances, (typed ? typed_res : res)};
	endtask

	// Result side: every accepted result is compared with the oldest expectation, and
	// ready is driven at random, or held low for the one long hold-off.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_distances.size() == 0) begin
					$display("%0t: unexpected result: expected none, got distance %0d over_bound %0b",
						$time, out_ch.payload.distance, out_ch.payload.over_bound);
					errors++;
				end else begin
					oldest = expected_distances.pop_front();
					if (out_ch.payload.distance !== oldest.distance) begin
						$display("%0t: distance: expected %0d, got %0d",
							$time, oldest.distance, out_ch.payload.distance);
						errors++;
					end
					if (out_ch.payload.over_bound !== oldest.over_bound) begin
						$display("%0t: over_bound: expected %0b, got %0b",
							$time, oldest.over_bound, out_ch.payload.over_bound);
						errors++;
					end
				end
			end
			if (hold_request && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= (quiet ? 0 : IDLE_PCT));
			end
		end
	end

	// A hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("bounded_osa_edit_distance: mismatch");
			$finish;
		end
	end

	initial begin : stimulus
		logic [7:0] base_str [$];
		logic [7:0] tgt_str [$];
		in_item_t   it;
		out_item_t  none;
		int         sent;
		int         len;
		int         mode;
		int         pos;
		int         pick;
		logic [7:0] alpha_base;
		logic [7:0] tmp;

		none          = '0;
		sent          = 0;
		in_ch.valid   = 1'b0;
		in_ch.payload = '0;
		out_ch.ready  = 1'b0;
		arst_n        = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: walk the table.
		for (int r = 0; r < DIR_ROWS; r++) begin
			it.kind      = DIRECTED[r].kind;
			it.char_code = DIRECTED[r].ch;
			it.cutoff    = DIRECTED[r].cut;
			push_item(it, DIRECTED[r].typed, {DIRECTED[r].exp_dist, DIRECTED[r].over});
		end

		// Random part. The receiver's long hold-off starts now, so the block fills with a
		// result while the sender keeps offering items.
		hold_request <= 1'b1;
		while (sent < RANDOM_ITEMS) begin
			// A stretch in the middle runs with no idling on either side.
			quiet <= (sent >= 500 && sent < 800);
			if ($urandom_range(99) < 8) begin
				// Noise: any kind, any field values, in any order.
				repeat ($urandom_range(1, 4)) begin
					it.kind      = kind_t'($urandom_range(3));
					it.char_code = 8'($urandom_range(255));
					it.cutoff    = 6'($urandom_range(63));
					push_item(it, 1'b0, none);
					sent++;
				end
			end else begin
				// A well-formed sequence: maybe a fresh source, then a few targets that are
				// mostly edited copies of it, each followed by a compute.
				mode       = $urandom_range(2);
				alpha_base = 8'($urandom_range(255));
				if ($urandom_range(3) != 0) begin
					it.kind      = KIND_CLEAR_SRC;
					it.char_code = 8'($urandom_range(255));
					it.cutoff    = 6'($urandom_range(63));
					push_item(it, 1'b0, none);
					sent++;
					base_str.delete();
				end
				// Mostly short sources, some up to the full length, a few that overflow.
				pick = $urandom_range(99);
				len  = (pick < 80) ? $urandom_range(0, 8) :
					(pick < 95) ? $urandom_range(9, STR_MAX) :
					$urandom_range(STR_MAX + 1, STR_MAX + 4);
				for (int k = 0; k < len; k++) begin
					tmp = pick_char(mode, alpha_base);
					base_str = {base_str, tmp};
					it.kind      = KIND_APPEND_SRC;
					it.char_code = tmp;
					it.cutoff    = 6'($urandom_range(63));
					push_item(it, 1'b0, none);
					sent++;
				end
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(9) < 6) begin
						// Edited copy: substitutions, deletions, insertions and swaps.
						tgt_str = base_str;
						repeat ($urandom_range(0, 4)) begin
							case ($urandom_range(3))
								0: if (tgt_str.size() > 0) begin
									pos = $urandom_range(tgt_str.size() - 1);
									tgt_str[pos] = pick_char(mode, alpha_base);
								end
								1: if (tgt_str.size() > 0)
									tgt_str.delete($urandom_range(tgt_str.size() - 1));
								2: tgt_str.insert($urandom_range(tgt_str.size()),
									pick_char(mode, alpha_base));
								default: if (tgt_str.size() > 1) begin
									pos = $urandom_range(tgt_str.size() - 2);
									tmp = tgt_str[pos];
									tgt_str[pos]   = tgt_str[pos+1];
									tgt_str[pos+1] = tmp;
								end
							endcase
						end
					end else begin
						// Unrelated target, now and then long enough to overflow.
						tgt_str.delete();
						len = ($urandom_range(99) < 95) ? $urandom_range(0, 10) :
							$urandom_range(STR_MAX - 2, STR_MAX + 3);
						repeat (len) tgt_str = {tgt_str, pick_char(mode, alpha_base)};
					end
					foreach (tgt_str[k]) begin
						it.kind      = KIND_APPEND_TGT;
						it.char_code = tgt_str[k];
						it.cutoff    = 6'($urandom_range(63));
						push_item(it, 1'b0, none);
						sent++;
					end
					// Cutoffs: both extremes often, mostly small, sometimes anything.
					pick         = $urandom_range(99);
					it.kind      = KIND_COMPUTE;
					it.char_code = 8'($urandom_range(255));
					it.cutoff    = (pick < 12) ? 6'd63 : (pick < 24) ? 6'd0 :
						(pick < 75) ? 6'($urandom_range(0, 8)) : 6'($urandom_range(63));
					push_item(it, 1'b0, none);
					sent++;
				end
			end
		end
		in_ch.valid <= 1'b0;

		while (expected_distances.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("bounded_osa_edit_distance: match");
		else
			$display("bounded_osa_edit_distance: mismatch");
		$finish;
	end

endmodule
